/* rtl/sphere_vertex_evaluator_unit_assert.svh */
// Assertion helpers for the sphere vertex evaluator.
`ifndef SPHERE_VERTEX_EVALUATOR_UNIT_ASSERT_SVH
`define SPHERE_VERTEX_EVALUATOR_UNIT_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define SVU_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked outside reset.
`define SVU_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/svu_pkg.sv */
package svu_pkg;

  localparam int CNT_W       = 11;
  localparam int RADIUS_W    = 15;
  localparam int CFG_W       = 15;
  localparam int CFG_IDX_W   = 2;
  // largest supported count; larger register values act as this
  localparam int MAX_DIVISIONS = 1024;
  // reciprocal ceil(2^55 / count), exact floor(i*2^33/count) after >> 22
  localparam int RECIP_W     = 56;
  localparam int RECIP_SHIFT = 22;
  localparam int PROD_W      = CNT_W + RECIP_W;
  localparam int FRAC_W      = 34;
  localparam int PHASE_W     = 32;
  localparam int TEX_W       = 17;
  localparam int CD_W        = 34;
  localparam int TRIG_W      = 32;
  localparam int OUT_W       = 16;

  localparam logic [CFG_IDX_W-1:0] REG_STACK  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SLICE  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RADIUS = 2'd2;

  localparam logic [CD_W-1:0] CORDIC_GAIN = 34'h26DD3B6A;

  typedef struct packed {
    logic               busy;
    logic [RECIP_W-1:0] value;
  } recip_t;

  typedef struct packed {
    logic             err;
    logic [TEX_W-1:0] tex_u;
    logic [TEX_W-1:0] tex_v;
  } side_t;

  // atan(2^-k) in turns, 2^32 per turn
  function automatic logic [31:0] atan_turn(input logic [4:0] k);
    logic [31:0] a;
    case (k)
      5'd0:  a = 32'h20000000;
      5'd1:  a = 32'h12E4051E;
      5'd2:  a = 32'h09FB385B;
      5'd3:  a = 32'h051111D4;
      5'd4:  a = 32'h028B0D43;
      5'd5:  a = 32'h0145D7E1;
      5'd6:  a = 32'h00A2F61E;
      5'd7:  a = 32'h00517C55;
      5'd8:  a = 32'h0028BE53;
      5'd9:  a = 32'h00145F2F;
      5'd10: a = 32'h000A2F98;
      5'd11: a = 32'h000517CC;
      5'd12: a = 32'h00028BE6;
      5'd13: a = 32'h000145F3;
      5'd14: a = 32'h0000A2FA;
      5'd15: a = 32'h0000517D;
      5'd16: a = 32'h000028BE;
      5'd17: a = 32'h0000145F;
      5'd18: a = 32'h00000A30;
      5'd19: a = 32'h00000518;
      5'd20: a = 32'h0000028C;
      5'd21: a = 32'h00000146;
      5'd22: a = 32'h000000A3;
      5'd23: a = 32'h00000051;
      default: a = 32'h0;
    endcase
    return a;
  endfunction

  function automatic logic signed [OUT_W-1:0] sat_norm(input logic signed [17:0] v);
    logic signed [OUT_W-1:0] r;
    if (v > 18'sd16384) begin
      r = 16'sd16384;
    end else if (v < -18'sd16384) begin
      r = -16'sd16384;
    end else begin
      r = v[OUT_W-1:0];
    end
    return r;
  endfunction

  function automatic logic signed [OUT_W-1:0] sat_pos(input logic signed [19:0] v);
    logic signed [OUT_W-1:0] r;
    if (v > 20'sd32767) begin
      r = 16'sd32767;
    end else if (v < -20'sd32767) begin
      r = -16'sd32767;
    end else begin
      r = v[OUT_W-1:0];
    end
    return r;
  endfunction

endpackage

/* rtl/svu_recip.sv */
// Bit-serial restoring divider: value = ceil(2^55 / divisor)
module svu_recip (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic [svu_pkg::CNT_W-1:0] divisor,
  output svu_pkg::recip_t           result
);

  localparam int CW = $clog2(svu_pkg::RECIP_W);

  logic                        busy;
  logic [CW-1:0]               cnt;
  logic [svu_pkg::RECIP_W-1:0] num;
  logic [svu_pkg::CNT_W-1:0]   rem;
  logic [svu_pkg::RECIP_W-1:0] quo;
  logic [svu_pkg::CNT_W:0]     trial;
  logic                        take;

  // one quotient bit per cycle
  assign trial = {rem, num[svu_pkg::RECIP_W-1]};
  assign take  = trial >= {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= '0;
    end else if (busy) begin
      cnt <= cnt + CW'(1);
      if (cnt == CW'(svu_pkg::RECIP_W - 1)) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      // dividend 2^55 + d - 1 gives the ceiling
      num <= {1'b1, {(svu_pkg::RECIP_W-1){1'b0}}} + svu_pkg::RECIP_W'(divisor)
             - svu_pkg::RECIP_W'(1);
      rem <= '0;
    end else if (busy) begin
      num <= {num[svu_pkg::RECIP_W-2:0], 1'b0};
      rem <= take ? svu_pkg::CNT_W'(trial - {1'b0, divisor}) : trial[svu_pkg::CNT_W-1:0];
      quo <= {quo[svu_pkg::RECIP_W-2:0], take};
    end
  end

  assign result.busy  = busy;
  assign result.value = quo;

endmodule

/* rtl/svu_cordic.sv */
// Pipelined CORDIC rotator, one step per stage, phase in turns (2^32)
module svu_cordic #(
  parameter int STEPS = 16
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               en,
  input  logic                               in_valid,
  input  logic [svu_pkg::PHASE_W-1:0]        phase,
  output logic                               out_valid,
  output logic signed [svu_pkg::TRIG_W-1:0]  cos_val,
  output logic signed [svu_pkg::TRIG_W-1:0]  sin_val
);

  localparam int DW = svu_pkg::CD_W;

  logic signed [DW-1:0] x [0:STEPS];
  logic signed [DW-1:0] y [0:STEPS];
  logic signed [DW-1:0] z [0:STEPS];
  logic                 fl [0:STEPS];
  logic                 vl [0:STEPS];

  logic                        flip;
  logic [svu_pkg::PHASE_W-1:0] res;
  logic signed [DW-1:0]        nx;
  logic signed [DW-1:0]        ny;

  // fold the left half-plane by half a turn
  assign flip = phase[svu_pkg::PHASE_W-1] ^ phase[svu_pkg::PHASE_W-2];
  assign res  = flip ? phase - 32'h8000_0000 : phase;

  always_ff @(posedge clk) begin
    if (rst) begin
      vl[0] <= 1'b0;
    end else if (en) begin
      vl[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x[0]  <= svu_pkg::CORDIC_GAIN;
      y[0]  <= '0;
      z[0]  <= DW'(signed'(res));
      fl[0] <= flip;
    end
  end

  // rotation steps
  for (genvar k = 0; k < STEPS; k++) begin : g_step
    logic signed [DW-1:0] dx;
    logic signed [DW-1:0] dy;
    logic signed [DW-1:0] at;

    assign dx = y[k] >>> k;
    assign dy = x[k] >>> k;
    assign at = signed'(DW'(svu_pkg::atan_turn(5'(k))));

    always_ff @(posedge clk) begin
      if (rst) begin
        vl[k+1] <= 1'b0;
      end else if (en) begin
        vl[k+1] <= vl[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        fl[k+1] <= fl[k];
        if (!z[k][DW-1]) begin
          x[k+1] <= x[k] - dx;
          y[k+1] <= y[k] + dy;
          z[k+1] <= z[k] - at;
        end else begin
          x[k+1] <= x[k] + dx;
          y[k+1] <= y[k] - dy;
          z[k+1] <= z[k] + at;
        end
      end
    end
  end

  // undo the fold
  assign nx = fl[STEPS] ? -x[STEPS] : x[STEPS];
  assign ny = fl[STEPS] ? -y[STEPS] : y[STEPS];

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= vl[STEPS];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cos_val <= nx[svu_pkg::TRIG_W-1:0];
      sin_val <= ny[svu_pkg::TRIG_W-1:0];
    end
  end

endmodule

/* rtl/sphere_vertex_evaluator_unit.sv */
// Sphere vertex evaluator: each request (stack_index, slice_index) yields one vertex of a
// latitude/longitude sphere: position, unit normal and texture coordinates. One request is
// taken per clock while in_stall is low; its result passes CORDIC_STEPS + 8 register stages:
// two index stages, the CORDIC pipeline (input register, one rotation step per stage, output
// register) and four product and output stages. After reset and after any write to
// stack_count or slice_count, in_stall stays high while a bit-serial divider refreshes the
// count reciprocals. out_stall freezes the whole pipeline; the output register keeps the
// last result.
`include "sphere_vertex_evaluator_unit_assert.svh"

module sphere_vertex_evaluator_unit #(
  parameter int CORDIC_STEPS  = 16
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  cfg_we,
  input  logic [svu_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [svu_pkg::CFG_W-1:0]             cfg_data,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic [svu_pkg::CNT_W-1:0]             stack_index,
  input  logic [svu_pkg::CNT_W-1:0]             slice_index,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic signed [svu_pkg::OUT_W-1:0]      pos_x,
  output logic signed [svu_pkg::OUT_W-1:0]      pos_y,
  output logic signed [svu_pkg::OUT_W-1:0]      pos_z,
  output logic signed [svu_pkg::OUT_W-1:0]      norm_x,
  output logic signed [svu_pkg::OUT_W-1:0]      norm_y,
  output logic signed [svu_pkg::OUT_W-1:0]      norm_z,
  output logic [svu_pkg::TEX_W-1:0]             tex_u,
  output logic [svu_pkg::TEX_W-1:0]             tex_v,
  output logic                                  index_error
);

  localparam int CNT_W   = svu_pkg::CNT_W;
  localparam int LAT     = CORDIC_STEPS + 2;
  localparam int MAX_DIV = svu_pkg::MAX_DIVISIONS;

  // configuration registers
  logic [CNT_W-1:0]             stack_count;
  logic [CNT_W-1:0]             slice_count;
  logic [svu_pkg::RADIUS_W-1:0] sphere_radius;
  logic                         recalc;

  always_ff @(posedge clk) begin
    if (rst) begin
      stack_count   <= CNT_W'(16);
      slice_count   <= CNT_W'(32);
      sphere_radius <= svu_pkg::RADIUS_W'(256);
      recalc        <= 1'b1;
    end else begin
      recalc <= cfg_we && (cfg_index == svu_pkg::REG_STACK || cfg_index == svu_pkg::REG_SLICE);
      if (cfg_we) begin
        case (cfg_index)
          svu_pkg::REG_STACK:  stack_count   <= cfg_data[CNT_W-1:0];
          svu_pkg::REG_SLICE:  slice_count   <= cfg_data[CNT_W-1:0];
          svu_pkg::REG_RADIUS: sphere_radius <= cfg_data[svu_pkg::RADIUS_W-1:0];
          default: ;
        endcase
      end
    end
  end

  // counts limited to the supported division range
  logic [CNT_W-1:0] st_lim;
  logic [CNT_W-1:0] sl_lim;
  logic [CNT_W-1:0] st_div;
  logic [CNT_W-1:0] sl_div;

  assign st_lim = (int'(stack_count) > MAX_DIV) ? CNT_W'(MAX_DIV) : stack_count;
  assign sl_lim = (int'(slice_count) > MAX_DIV) ? CNT_W'(MAX_DIV) : slice_count;
  assign st_div = (st_lim == '0) ? CNT_W'(1) : st_lim;
  assign sl_div = (sl_lim == '0) ? CNT_W'(1) : sl_lim;

  svu_pkg::recip_t rcp_u;
  svu_pkg::recip_t rcp_v;

  svu_recip u_rcp_u (
    .clk     (clk),
    .rst     (rst),
    .start   (recalc),
    .divisor (st_div),
    .result  (rcp_u)
  );

  svu_recip u_rcp_v (
    .clk     (clk),
    .rst     (rst),
    .start   (recalc),
    .divisor (sl_div),
    .result  (rcp_v)
  );

  // global advance: move when the output register is free or being drained
  logic en;
  logic accept;

  assign en       = !out_valid || !out_stall;
  assign in_stall = !en || recalc || rcp_u.busy || rcp_v.busy;
  assign accept   = in_valid && !in_stall;

  // stage 0: range check and index times reciprocal
  logic                        v0;
  logic                        err0;
  logic [svu_pkg::PROD_W-1:0]  pi0;
  logic [svu_pkg::PROD_W-1:0]  pj0;

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
    end else if (en) begin
      v0 <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      err0 <= (st_lim == '0) || (sl_lim == '0) || (stack_index > st_lim)
              || (slice_index > sl_lim);
      pi0  <= svu_pkg::PROD_W'(stack_index) * svu_pkg::PROD_W'(rcp_u.value);
      pj0  <= svu_pkg::PROD_W'(slice_index) * svu_pkg::PROD_W'(rcp_v.value);
    end
  end

  // stage 1: phases and texture coordinates from floor(index*2^33/count)
  logic [svu_pkg::FRAC_W-1:0]  fu;
  logic [svu_pkg::FRAC_W-1:0]  fv;
  logic                        v1;
  logic [svu_pkg::PHASE_W-1:0] pu1;
  logic [svu_pkg::PHASE_W-1:0] pv1;
  svu_pkg::side_t              side1;

  assign fu = pi0[svu_pkg::RECIP_SHIFT +: svu_pkg::FRAC_W];
  assign fv = pj0[svu_pkg::RECIP_SHIFT +: svu_pkg::FRAC_W];

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= v0;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pu1         <= 32'h4000_0000 - svu_pkg::PHASE_W'((fu + svu_pkg::FRAC_W'(2)) >> 2);
      pv1         <= svu_pkg::PHASE_W'((fv + svu_pkg::FRAC_W'(1)) >> 1);
      side1.err   <= err0;
      side1.tex_u <= svu_pkg::TEX_W'((fu + svu_pkg::FRAC_W'(17'h10000)) >> 17);
      side1.tex_v <= svu_pkg::TEX_W'(17'h10000)
                     - svu_pkg::TEX_W'((fv + svu_pkg::FRAC_W'(17'h10000)) >> 17);
    end
  end

  // trig for both angles
  logic                               vc_u;
  logic                               vc_v;
  logic signed [svu_pkg::TRIG_W-1:0]  cu;
  logic signed [svu_pkg::TRIG_W-1:0]  su;
  logic signed [svu_pkg::TRIG_W-1:0]  cv;
  logic signed [svu_pkg::TRIG_W-1:0]  sv;

  svu_cordic #(.STEPS(CORDIC_STEPS)) u_cordic_u (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (v1),
    .phase     (pu1),
    .out_valid (vc_u),
    .cos_val   (cu),
    .sin_val   (su)
  );

  svu_cordic #(.STEPS(CORDIC_STEPS)) u_cordic_v (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (v1),
    .phase     (pv1),
    .out_valid (vc_v),
    .cos_val   (cv),
    .sin_val   (sv)
  );

  // side data follows the CORDIC latency
  svu_pkg::side_t side_d [0:LAT-1];

  always_ff @(posedge clk) begin
    if (en) begin
      side_d[0] <= side1;
      for (int k = 1; k < LAT; k++) begin
        side_d[k] <= side_d[k-1];
      end
    end
  end

  // stage A: trig products
  localparam int CD_SU = svu_pkg::CD_W;
  logic                        v_a;
  logic signed [63:0]          p_x;
  logic signed [63:0]          p_y;
  logic signed [CD_SU-1:0]     su_a;
  svu_pkg::side_t              side_a;

  always_ff @(posedge clk) begin
    if (rst) begin
      v_a <= 1'b0;
    end else if (en) begin
      v_a <= vc_u && vc_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p_x    <= cu * cv;
      p_y    <= cu * sv;
      su_a   <= CD_SU'(su);
      side_a <= side_d[LAT-1];
    end
  end

  // stage B: round products to Q1.30
  logic                        v_b;
  logic signed [63:0]          rx;
  logic signed [63:0]          ry;
  logic signed [CD_SU-1:0]     tx;
  logic signed [CD_SU-1:0]     ty;
  logic signed [CD_SU-1:0]     su_b;
  svu_pkg::side_t              side_b;

  assign rx = p_x + (64'sd1 <<< 29);
  assign ry = p_y + (64'sd1 <<< 29);

  always_ff @(posedge clk) begin
    if (rst) begin
      v_b <= 1'b0;
    end else if (en) begin
      v_b <= v_a;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      tx     <= rx[63:30];
      ty     <= ry[63:30];
      su_b   <= su_a;
      side_b <= side_a;
    end
  end

  // stage C: radius products and normals
  logic                        v_c;
  logic signed [16:0]          rad_s;
  logic signed [CD_SU-1:0]     nrx;
  logic signed [CD_SU-1:0]     nry;
  logic signed [CD_SU-1:0]     nrz;
  logic signed [49:0]          q_x;
  logic signed [49:0]          q_y;
  logic signed [49:0]          q_z;
  logic signed [svu_pkg::OUT_W-1:0] n_x;
  logic signed [svu_pkg::OUT_W-1:0] n_y;
  logic signed [svu_pkg::OUT_W-1:0] n_z;
  svu_pkg::side_t              side_c;

  assign rad_s = signed'({2'b00, sphere_radius});
  assign nrx   = tx + CD_SU'(1 << 15);
  assign nry   = ty + CD_SU'(1 << 15);
  assign nrz   = su_b + CD_SU'(1 << 15);

  always_ff @(posedge clk) begin
    if (rst) begin
      v_c <= 1'b0;
    end else if (en) begin
      v_c <= v_b;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      q_x    <= 50'(rad_s * tx);
      q_y    <= 50'(rad_s * ty);
      q_z    <= 50'(rad_s * su_b);
      n_x    <= svu_pkg::sat_norm(nrx[33:16]);
      n_y    <= svu_pkg::sat_norm(nry[33:16]);
      n_z    <= svu_pkg::sat_norm(nrz[33:16]);
      side_c <= side_b;
    end
  end

  // stage D: output register with rounding, saturation and error zeroing
  logic signed [49:0] rqx;
  logic signed [49:0] rqy;
  logic signed [49:0] rqz;

  assign rqx = q_x + (50'sd1 <<< 29);
  assign rqy = q_y + (50'sd1 <<< 29);
  assign rqz = q_z + (50'sd1 <<< 29);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= v_c;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      index_error <= side_c.err;
      if (side_c.err) begin
        pos_x  <= '0;
        pos_y  <= '0;
        pos_z  <= '0;
        norm_x <= '0;
        norm_y <= '0;
        norm_z <= '0;
        tex_u  <= '0;
        tex_v  <= '0;
      end else begin
        pos_x  <= svu_pkg::sat_pos(rqx[49:30]);
        pos_y  <= svu_pkg::sat_pos(rqy[49:30]);
        pos_z  <= svu_pkg::sat_pos(rqz[49:30]);
        norm_x <= n_x;
        norm_y <= n_y;
        norm_z <= n_z;
        tex_u  <= side_c.tex_u;
        tex_v  <= side_c.tex_v;
      end
    end
  end

  // checks
  `SVU_ASSERT_NOW(a_refresh_stall, (recalc || rcp_u.busy || rcp_v.busy), in_stall,
    "request taken during reciprocal refresh")
  `SVU_ASSERT_NOW(a_err_zero, (out_valid && index_error),
    (pos_x == 16'sd0 && norm_z == 16'sd0 && tex_u == 17'd0 && tex_v == 17'd0),
    "index error result not zeroed")
  `SVU_ASSERT_NOW(a_norm_range, out_valid,
    (norm_x <= 16'sd16384 && norm_x >= -16'sd16384 && norm_y <= 16'sd16384
     && norm_y >= -16'sd16384), "normal out of range")
  `SVU_ASSERT_NEXT(a_cordic_align, (en && v1), (vc_u == vc_v), "CORDIC lanes out of step")

endmodule

/* tb/sv/sphere_vertex_evaluator_unit_checker.sv */
module sphere_vertex_evaluator_unit_checker (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [svu_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [svu_pkg::CFG_W-1:0]         cfg_data,
  input  logic                              in_valid,
  input  logic                              in_stall,
  input  logic [svu_pkg::CNT_W-1:0]         stack_index,
  input  logic [svu_pkg::CNT_W-1:0]         slice_index,
  input  logic                              out_valid,
  input  logic                              out_stall,
  input  logic signed [svu_pkg::OUT_W-1:0]  pos_x,
  input  logic signed [svu_pkg::OUT_W-1:0]  pos_y,
  input  logic signed [svu_pkg::OUT_W-1:0]  pos_z,
  input  logic signed [svu_pkg::OUT_W-1:0]  norm_x,
  input  logic signed [svu_pkg::OUT_W-1:0]  norm_y,
  input  logic signed [svu_pkg::OUT_W-1:0]  norm_z,
  input  logic [svu_pkg::TEX_W-1:0]         tex_u,
  input  logic [svu_pkg::TEX_W-1:0]         tex_v,
  input  logic                              index_error,
  output int                                mismatch_count,
  output int                                vertices_pending,
  output int                                vertices_checked,
  output int                                index_errors_seen
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_DIV = 1024;
  localparam int STEPS   = 16;

  typedef struct {
    logic signed [svu_pkg::OUT_W-1:0] px, py, pz, nx, ny, nz;
    logic [svu_pkg::TEX_W-1:0]        u, v;
    logic                             err;
  } vertex_t;

  vertex_t vertex_queue[$];
  logic [svu_pkg::CNT_W-1:0]    stacks_reg, slices_reg;
  logic [svu_pkg::RADIUS_W-1:0] radius_reg;

  // arctangent of 2^-k, one turn = 2^32
  longint arctan_turns[24] = '{
    64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4, 64'h028B0D43, 64'h0145D7E1,
    64'h00A2F61E, 64'h00517C55, 64'h0028BE53, 64'h00145F2F, 64'h000A2F98, 64'h000517CC,
    64'h00028BE6, 64'h000145F3, 64'h0000A2FA, 64'h0000517D, 64'h000028BE, 64'h0000145F,
    64'h00000A30, 64'h00000518, 64'h0000028C, 64'h00000146, 64'h000000A3, 64'h00000051};

  function automatic longint rnd_shift(longint v, int n);
    return (v + (longint'(1) <<< (n - 1))) >>> n;
  endfunction

  function automatic longint clip(longint v, longint lim);
    return v > lim ? lim : (v < -lim ? -lim : v);
  endfunction

  // rotate the gain vector by a phase; returns cos and sin in Q1.30
  function automatic void rotate_phase(input bit [31:0] phase, output longint c,
                                       output longint s);
    bit [31:0] folded;
    bit        flip;
    longint    x, y, z, dx, dy;
    flip   = ((phase + 32'h40000000) & 32'h80000000) != 0;
    folded = flip ? phase - 32'h80000000 : phase;
    z = longint'(signed'(folded));
    x = 64'h26DD3B6A;
    y = 0;
    for (int k = 0; k < STEPS; k++) begin
      dx = y >>> k;
      dy = x >>> k;
      if (z >= 0) begin
        x -= dx; y += dy; z -= arctan_turns[k];
      end else begin
        x += dx; y -= dy; z += arctan_turns[k];
      end
    end
    c = flip ? -x : x;
    s = flip ? -y : y;
  endfunction

  function automatic vertex_t compute_vertex(input int unsigned i, input int unsigned j);
    vertex_t     vx;
    longint unsigned st, sl, fu, fv;
    bit [31:0]   pu, pv;
    longint      cu, su, cv, sv, tx, ty, r;
    st = stacks_reg > MAX_DIV ? MAX_DIV : stacks_reg;
    sl = slices_reg > MAX_DIV ? MAX_DIV : slices_reg;
    vx = '{default: '0};
    if (st == 0 || sl == 0 || i > st || j > sl) begin
      vx.err = 1'b1;
      return vx;
    end
    pu = 32'(64'h40000000 - (((longint'(i) << 32) + st) / (st * 2)));
    pv = 32'((((longint'(j) << 33) + sl) / (sl * 2)));
    rotate_phase(pu, cu, su);
    rotate_phase(pv, cv, sv);
    tx = rnd_shift(cu * cv, 30);
    ty = rnd_shift(cu * sv, 30);
    r  = longint'(radius_reg);
    vx.px = 16'(clip(rnd_shift(r * tx, 30), 32767));
    vx.py = 16'(clip(rnd_shift(r * ty, 30), 32767));
    vx.pz = 16'(clip(rnd_shift(r * su, 30), 32767));
    vx.nx = 16'(clip(rnd_shift(tx, 16), 16384));
    vx.ny = 16'(clip(rnd_shift(ty, 16), 16384));
    vx.nz = 16'(clip(rnd_shift(su, 16), 16384));
    fu = ((longint'(i) << 17) + st) / (st * 2);
    fv = ((longint'(j) << 17) + sl) / (sl * 2);
    vx.u = 17'(fu);
    vx.v = 17'(65536 - fv);
    return vx;
  endfunction

  task automatic report(input string what, input longint got, input longint want);
    $display("%0t: %s mismatch: got %0d expected %0d", $realtime, what, got, want);
    mismatch_count++;
  endtask

  always @(posedge clk) begin
    vertex_t want;
    if (rst) begin
      stacks_reg = 11'd16;
      slices_reg = 11'd32;
      radius_reg = 15'd256;
      vertex_queue.delete();
      mismatch_count    = 0;
      vertices_checked  = 0;
      index_errors_seen = 0;
      vertices_pending  = 0;
    end else begin
      // register writes
      if (cfg_we) begin
        case (cfg_index)
          svu_pkg::REG_STACK:  stacks_reg = cfg_data[svu_pkg::CNT_W-1:0];
          svu_pkg::REG_SLICE:  slices_reg = cfg_data[svu_pkg::CNT_W-1:0];
          svu_pkg::REG_RADIUS: radius_reg = cfg_data[svu_pkg::RADIUS_W-1:0];
          default: ;
        endcase
      end
      // accepted result against oldest prediction
      if (out_valid && !out_stall) begin
        if (vertex_queue.size() == 0) begin
          report("outstanding request count", 0, 1);
        end else begin
          want = vertex_queue.pop_front();
          vertices_checked++;
          if (index_error) index_errors_seen++;
          if (pos_x !== want.px) report("pos_x", pos_x, want.px);
          if (pos_y !== want.py) report("pos_y", pos_y, want.py);
          if (pos_z !== want.pz) report("pos_z", pos_z, want.pz);
          if (norm_x !== want.nx) report("norm_x", norm_x, want.nx);
          if (norm_y !== want.ny) report("norm_y", norm_y, want.ny);
          if (norm_z !== want.nz) report("norm_z", norm_z, want.nz);
          if (tex_u !== want.u) report("tex_u", tex_u, want.u);
          if (tex_v !== want.v) report("tex_v", tex_v, want.v);
          if (index_error !== want.err) report("index_error", index_error, want.err);
        end
      end
      // accepted request
      if (in_valid && !in_stall)
        vertex_queue.insert(vertex_queue.size(), compute_vertex(stack_index, slice_index));
      vertices_pending = vertex_queue.size();
    end
  end

endmodule

/* tb/sv/sphere_vertex_evaluator_unit_test.sv */
module sphere_vertex_evaluator_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  // register index with no register behind it
  localparam logic [svu_pkg::CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [svu_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [svu_pkg::CFG_W-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [svu_pkg::CNT_W-1:0] stack_index = '0, slice_index = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [svu_pkg::OUT_W-1:0] pos_x, pos_y, pos_z, norm_x, norm_y, norm_z;
  logic [svu_pkg::TEX_W-1:0] tex_u, tex_v;
  logic index_error;
  int mismatch_count, vertices_pending, vertices_checked, index_errors_seen;

  int unsigned stacks_now = 16, slices_now = 32;
  bit quiet_sender, quiet_receiver;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  sphere_vertex_evaluator_unit u_dut (.*);
  sphere_vertex_evaluator_unit_checker u_checker (.*);

  // one request per call, random gap in front unless the sender is quiet
  task automatic send_request(input int unsigned i, input int unsigned j);
    int gap;
    gap = quiet_sender ? 0 : $urandom_range(0, 12);
    repeat (gap) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid    <= 1'b1;
    stack_index <= svu_pkg::CNT_W'(i);
    slice_index <= svu_pkg::CNT_W'(j);
    do @(posedge clk); while (in_stall);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    wait (vertices_pending == 0);
    repeat (30) @(posedge clk);
  endtask

  task automatic write_reg(input logic [svu_pkg::CFG_IDX_W-1:0] idx, input int unsigned val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= svu_pkg::CFG_W'(val);
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == svu_pkg::REG_STACK) stacks_now = val & 11'h7FF;
    if (idx == svu_pkg::REG_SLICE) slices_now = val & 11'h7FF;
  endtask

  function automatic int unsigned pick_index(input int unsigned cnt);
    int unsigned lim, roll;
    lim  = cnt > 1024 ? 1024 : cnt;
    roll = $urandom_range(0, 99);
    if (roll < 80) return $urandom_range(0, lim);
    if (roll < 90) return lim + 1;
    return $urandom_range(0, 2047);
  endfunction

  task automatic random_requests(input int n);
    for (int k = 0; k < n; k++) begin
      if (k % 40 == 0) quiet_sender = ($urandom_range(0, 3) == 0);
      send_request(pick_index(stacks_now), pick_index(slices_now));
    end
  endtask

  // output side backpressure
  initial begin
    int gap;
    @(negedge rst);
    forever begin
      if ($urandom_range(0, 30) == 0) quiet_receiver = !quiet_receiver;
      gap = quiet_receiver ? 0 : $urandom_range(0, 12);
      repeat (gap) begin
        out_stall <= 1'b1;
        @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
    end
  end

  initial begin
    #20ms;
    $display("sphere_vertex_evaluator_unit verification failed");
    $finish;
  end

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // directed: poles, seam, bounds, out-of-range under reset settings
    send_request(0, 0);
    send_request(16, 32);
    send_request(8, 0);
    send_request(8, 8);
    send_request(8, 16);
    send_request(8, 24);
    send_request(4, 5);
    send_request(12, 31);
    send_request(17, 0);
    send_request(0, 33);
    send_request(2047, 2047);
    send_request(1024, 1024);
    send_request(1365, 682);
    send_request(682, 1365);
    drain();

    // register sweep: minimum, maximum, above limit, zero counts, unknown index
    write_reg(svu_pkg::REG_STACK, 1);
    write_reg(svu_pkg::REG_SLICE, 1);
    write_reg(svu_pkg::REG_RADIUS, 0);
    send_request(0, 0);
    send_request(1, 1);
    send_request(2, 1);
    random_requests(60);
    drain();

    write_reg(svu_pkg::REG_STACK, 1024);
    write_reg(svu_pkg::REG_SLICE, 1024);
    write_reg(svu_pkg::REG_RADIUS, 32767);
    send_request(1024, 1024);
    send_request(512, 256);
    send_request(1025, 0);
    random_requests(100);
    drain();

    write_reg(svu_pkg::REG_STACK, 2047);
    write_reg(svu_pkg::REG_SLICE, 1500);
    write_reg(REG_UNUSED, 15'h7FFF);
    random_requests(80);
    drain();

    write_reg(svu_pkg::REG_STACK, 0);
    write_reg(svu_pkg::REG_SLICE, 7);
    random_requests(30);
    drain();
    write_reg(svu_pkg::REG_STACK, 5);
    write_reg(svu_pkg::REG_SLICE, 0);
    random_requests(30);
    drain();

    write_reg(svu_pkg::REG_STACK, 3);
    write_reg(svu_pkg::REG_SLICE, 7);
    write_reg(svu_pkg::REG_RADIUS, 100);
    random_requests(80);
    drain();

    for (int p = 0; p < 4; p++) begin
      write_reg(svu_pkg::REG_STACK, $urandom_range(1, 1100));
      write_reg(svu_pkg::REG_SLICE, $urandom_range(1, 1100));
      write_reg(svu_pkg::REG_RADIUS, $urandom_range(0, 32767));
      random_requests(60);
      drain();
    end

    $display("Checked %0d vertices (%0d flagged out of range) over minimum, maximum,",
             vertices_checked, index_errors_seen);
    $display("above-limit, zero and random count and radius settings.");
    if (mismatch_count == 0)
      $display("sphere_vertex_evaluator_unit verification clean");
    else
      $display("sphere_vertex_evaluator_unit verification failed");
    $finish;
  end

endmodule
